FILE: rtl/ogcl_pkg.sv
// ----------------------------------------------------------------------------
// Occupancy grid cost lookup package
// Shared types and constants for the cost lookup core and its RAM.
// ----------------------------------------------------------------------------
package ogcl_pkg;

    localparam int unsigned LIM_W   = 13;   // holds a column or row limit up to 4096
    localparam int unsigned POS_W   = 34;   // signed cell coordinate after division
    localparam int unsigned NUM_W   = 33;   // exact point minus origin
    localparam int unsigned DIV_W   = 31;   // cell size and remainder
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned ADDR_W_CFG = 5;

    localparam logic [7:0] UNKNOWN_COST = 8'd30;
    localparam logic [7:0] MAX_COST     = 8'd100;
    localparam logic [7:0] ZERO_COST    = 8'd0;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_CELL  = 2'd2;

    localparam logic [2:0] REG_MAP_LOADED  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X    = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE   = 3'd3;
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd4;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd5;
    localparam logic [2:0] REG_LETHAL_COST = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_LOOK,
        S_WAIT
    } state_t;

endpackage

FILE: rtl/ogcl_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write port, read data registered.
// ----------------------------------------------------------------------------
module ogcl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]                 wdata,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/occupancy_grid_cost_lookup_core.sv
// ----------------------------------------------------------------------------
// Occupancy grid cost lookup core
// Stores a grid of signed 8-bit cells and returns the cost of a queried cell.
// ----------------------------------------------------------------------------
// Usage: words arrive on the s_ stream; op 0 writes one cell, op 1 queries a
// Q16.16 metric point, op 2 queries a cell by column and row. Each query
// yields one cost word on the m_ stream; writes and op 3 yield nothing.
// Registers are to be written over the APB port only while the block is
// idle; the block itself does not enforce it. A write is done in the cycle
// it is accepted; a cell query goes via S_LOOK and S_WAIT to the output
// register. A point query first runs a restoring divider giving one quotient
// bit per cycle, x and y together; no map or a zero cell size skips it.
// One word is worked on at a time; s_tready is high only while idle.
// The output register lets a new word be accepted while a cost still waits;
// if the receiver stalls, a finished lookup holds until the register frees.
// Reset clears the registers to their defaults and the control state; the
// grid RAM is not cleared, and a cell must be written before it is read.
// ----------------------------------------------------------------------------
module occupancy_grid_cost_lookup_core
    import ogcl_pkg::*;
#(
    parameter int unsigned MAX_COLS = 256,
    parameter int unsigned MAX_ROWS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // op[1:0], point_x[33:2], point_y[65:34], cell_col[81:66],
    // cell_row[97:82], cell_value[105:98], zero fill
    input  logic [111:0]          s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cost[7:0]
    output logic [7:0]            m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W_CFG-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int unsigned ADDR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int unsigned CIDX   = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
    localparam int unsigned RIDX   = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;

    // Input fields
    logic [1:0]         in_op;
    logic signed [31:0] in_px, in_py;
    logic signed [15:0] in_col, in_row;
    logic [7:0]         in_val;

    assign in_op  = s_tdata[1:0];
    assign in_px  = s_tdata[33:2];
    assign in_py  = s_tdata[65:34];
    assign in_col = s_tdata[81:66];
    assign in_row = s_tdata[97:82];
    assign in_val = s_tdata[105:98];

    // Configuration registers
    logic               map_loaded_reg;
    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [30:0]        cell_size_reg;
    logic [8:0]         grid_width_reg, grid_height_reg;
    logic [7:0]         lethal_cost_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_loaded_reg  <= 1'b0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cell_size_reg   <= 31'd6554;
            grid_width_reg  <= 9'd256;
            grid_height_reg <= 9'd256;
            lethal_cost_reg <= 8'd100;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MAP_LOADED:  map_loaded_reg  <= pwdata[0];
                REG_ORIGIN_X:    origin_x_reg    <= pwdata;
                REG_ORIGIN_Y:    origin_y_reg    <= pwdata;
                REG_CELL_SIZE:   cell_size_reg   <= pwdata[30:0];
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[8:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[8:0];
                REG_LETHAL_COST: lethal_cost_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MAP_LOADED:  prdata = {31'd0, map_loaded_reg};
            REG_ORIGIN_X:    prdata = origin_x_reg;
            REG_ORIGIN_Y:    prdata = origin_y_reg;
            REG_CELL_SIZE:   prdata = {1'b0, cell_size_reg};
            REG_GRID_WIDTH:  prdata = {23'd0, grid_width_reg};
            REG_GRID_HEIGHT: prdata = {23'd0, grid_height_reg};
            REG_LETHAL_COST: prdata = {24'd0, lethal_cost_reg};
            default:         prdata = '0;
        endcase
    end

    // Limits in use, clamped to the RAM's geometry
    logic [LIM_W-1:0] used_cols, used_rows;

    assign used_cols = ({4'd0, grid_width_reg} > LIM_W'(MAX_COLS)) ?
                       LIM_W'(MAX_COLS) : {4'd0, grid_width_reg};
    assign used_rows = ({4'd0, grid_height_reg} > LIM_W'(MAX_ROWS)) ?
                       LIM_W'(MAX_ROWS) : {4'd0, grid_height_reg};

    // Control
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             div_skip;
    logic             s_fire, out_free;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign div_skip = !map_loaded_reg || (cell_size_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (in_op == OP_CELL) begin
                        state_next = S_LOOK;
                    end else if (in_op == OP_POINT) begin
                        state_next = div_skip ? S_LOOK : S_DIV;
                    end
                end
            end
            S_DIV:   if (cnt_reg == CNT_W'(NUM_W - 1)) state_next = S_LOOK;
            S_LOOK:  state_next = S_WAIT;
            S_WAIT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Write-side checks straight from the input word
    logic              wr_inside;
    logic [ADDR_W-1:0] wr_addr;

    assign wr_inside = !in_col[15] && !in_row[15] &&
                       ({1'b0, in_col} < {4'd0, used_cols}) &&
                       ({1'b0, in_row} < {4'd0, used_rows});
    assign wr_addr = ADDR_W'(in_row[RIDX-1:0]) * ADDR_W'(MAX_COLS) +
                     ADDR_W'(in_col[CIDX-1:0]);

    // Divider: x and y lanes share the step counter
    logic [NUM_W-1:0]  num_x, num_y;
    logic [NUM_W-1:0]  dv_x_reg, dv_y_reg;
    logic [DIV_W-1:0]  rem_x_reg, rem_y_reg;
    logic              neg_x_reg, neg_y_reg;
    logic [DIV_W:0]    sh_x, sh_y;
    logic [DIV_W+1:0]  df_x, df_y;

    assign num_x = {in_px[31], in_px} - {origin_x_reg[31], origin_x_reg};
    assign num_y = {in_py[31], in_py} - {origin_y_reg[31], origin_y_reg};
    assign sh_x  = {rem_x_reg, dv_x_reg[NUM_W-1]};
    assign sh_y  = {rem_y_reg, dv_y_reg[NUM_W-1]};
    assign df_x  = {1'b0, sh_x} - {2'b0, cell_size_reg};
    assign df_y  = {1'b0, sh_y} - {2'b0, cell_size_reg};

    // Cell coordinates as wide signed values; all-ones marks outside
    logic signed [POS_W-1:0] col_reg, row_reg;
    logic                    inside_reg;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    look_inside;

    assign look_inside = !col_reg[POS_W-1] && !row_reg[POS_W-1] &&
                         (col_reg[NUM_W-1:0] < NUM_W'(used_cols)) &&
                         (row_reg[NUM_W-1:0] < NUM_W'(used_rows));
    assign rd_addr = ADDR_W'(row_reg[RIDX-1:0]) * ADDR_W'(MAX_COLS) +
                     ADDR_W'(col_reg[CIDX-1:0]);

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                cnt_reg   <= '0;
                rem_x_reg <= '0;
                rem_y_reg <= '0;
                dv_x_reg  <= num_x;
                dv_y_reg  <= num_y;
                neg_x_reg <= num_x[NUM_W-1];
                neg_y_reg <= num_y[NUM_W-1];
                // A point starts outside, so a zero cell size with a map loaded gives the lethal cost.
                col_reg   <= (in_op == OP_POINT) ? '1 : POS_W'(in_col);
                row_reg   <= POS_W'(in_row);
            end
            S_DIV: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!df_x[DIV_W+1]) begin
                    rem_x_reg <= df_x[DIV_W-1:0];
                end else begin
                    rem_x_reg <= sh_x[DIV_W-1:0];
                end
                if (!df_y[DIV_W+1]) begin
                    rem_y_reg <= df_y[DIV_W-1:0];
                end else begin
                    rem_y_reg <= sh_y[DIV_W-1:0];
                end
                dv_x_reg <= {dv_x_reg[NUM_W-2:0], !df_x[DIV_W+1]};
                dv_y_reg <= {dv_y_reg[NUM_W-2:0], !df_y[DIV_W+1]};
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    // A negative offset always floors to a negative cell.
                    col_reg <= neg_x_reg ? '1 :
                               POS_W'({dv_x_reg[NUM_W-2:0], !df_x[DIV_W+1]});
                    row_reg <= neg_y_reg ? '1 :
                               POS_W'({dv_y_reg[NUM_W-2:0], !df_y[DIV_W+1]});
                end
            end
            S_LOOK: inside_reg <= look_inside;
            default: ;
        endcase
    end

    // Grid memory
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_rdata;

    assign ram_we   = s_fire && (in_op == OP_WRITE) && wr_inside;
    assign ram_addr = (state_reg == S_IDLE) ? wr_addr : rd_addr;

    ogcl_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_val),
        .rdata (ram_rdata)
    );

    // Cost rules and output register
    logic [7:0] cost;

    always_comb begin
        if (!map_loaded_reg) begin
            cost = ZERO_COST;
        end else if (!inside_reg) begin
            cost = lethal_cost_reg;
        end else if (ram_rdata[7]) begin
            cost = UNKNOWN_COST;
        end else if (ram_rdata > MAX_COST) begin
            cost = MAX_COST;
        end else begin
            cost = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_WAIT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_WAIT && out_free) begin
            m_tdata_reg <= cost;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
